// ----- rtl/core/lru_ttl_byte_budget_cache_macros.svh -----
// assertion macros for the cache directory
`ifndef LRU_TTL_BYTE_BUDGET_CACHE_MACROS_SVH
`define LRU_TTL_BYTE_BUDGET_CACHE_MACROS_SVH
// assert a property that holds at every clock edge outside reset
`define LTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// assert an implication from one cycle into the next
`define LTC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ----- rtl/core/ltbc_pkg.sv -----
// shared types and codes of the cache directory
`timescale 1ns / 1ps
`default_nettype none
package ltbc_pkg;
   typedef enum logic [1:0] {
      REQ_GET    = 2'd0,
      REQ_PUT    = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_TICK   = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_HIT      = 4'd0,
      ST_MISS     = 4'd1,
      ST_EXPIRED  = 4'd2,
      ST_INSERTED = 4'd3,
      ST_UPDATED  = 4'd4,
      ST_TOO_BIG  = 4'd5,
      ST_REMOVED  = 4'd6,
      ST_ABSENT   = 4'd7,
      ST_TICK     = 4'd8
   } status_type;

   localparam int TIME_BITS = 48;
   localparam int SIZE_BITS = 24;
   localparam int DATA_BITS = 32;
   localparam int CNT_BITS  = 7;

   // register byte addresses
   localparam logic [2:0] ADDR_CAPACITY = 3'd0;
   localparam logic [2:0] ADDR_TTL      = 3'd4;

   localparam logic [31:0] CAPACITY_RESET = 32'd1048576;
   localparam logic [31:0] TTL_RESET      = 32'd1000;
endpackage
`default_nettype wire

// ----- rtl/core/lru_ttl_byte_budget_cache.sv -----
// keyed cache directory with lru order, expiry and byte budget
// every pass over the entry memory is a sweep of all ENTRIES addresses in order; one item at a time
// tick or oversize put: answered without a sweep; get miss or absent remove: search sweep only
// get hit, expired get, remove, insert, update: search sweep, then a rank sweep; puts then write and check budget
// full table adds a victim search sweep and a rank sweep, as does each budget eviction; next item after result taken
// reset is synchronous, clears valid bits, usage and time, loads registers with reset values; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
`include "lru_ttl_byte_budget_cache_macros.svh"
module lru_ttl_byte_budget_cache #(
   parameter int ENTRIES  = 64,
   parameter int KEY_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: key_tag[31:0], payload_ref[63:32], value_size[87:64]
   input  wire logic [87:0]  req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: status[3:0], hit_payload[35:4], usage_after[67:36], evicted_count[74:68], 0
   output logic [79:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import ltbc_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [31:0]          pay;
      logic [SIZE_BITS-1:0] size;
      logic [TIME_BITS-1:0] expiry;
      logic [IW-1:0]        rank;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_DECIDE, S_LRU, S_DROP, S_FREE, S_BUMP, S_WRITE, S_BUDGET, S_OUT
   } state_type;

   // entry memory and per-entry valid bits
   entry_type mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   entry_type rd_ff;

   state_type state_ff;
   logic [31:0] cap_ff, ttl_ff;
   logic [32:0] usage_ff;             // one spare bit for a put that overshoots
   logic [TIME_BITS-1:0] now_ff;

   logic [1:0]           kind_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [31:0]          pay_ff;
   logic [SIZE_BITS-1:0] size_ff;

   // sweep control
   logic [CW-1:0] rd_ptr_ff;          // next address to read
   logic [IW-1:0] cur_ff;             // address of data in rd_ff
   logic          rd_live_ff;         // rd_ff holds a sweep entry
   logic          found_ff;
   logic [IW-1:0] slot_ff;            // matched / target slot
   logic [IW-1:0] victim_ff;
   logic [IW-1:0] vrank_ff;
   logic          vfound_ff;
   logic [IW-1:0] rank_ref_ff;        // rank of dropped / promoted entry
   logic [1:0]    mode_ff;            // shift kind in S_BUMP
   logic [CW-1:0] evict_ff;
   logic [3:0]    status_ff;
   logic [31:0]   hit_ff;
   logic          budget_ff;          // drop came from budget loop

   localparam logic [1:0] SH_DEC = 2'd0;  // decrement ranks above ref
   localparam logic [1:0] SH_PROMO = 2'd1; // increment ranks below ref
   localparam logic [1:0] SH_ALL = 2'd2;  // increment all

   logic rsp_valid_ff;
   logic [79:0] rsp_data_ff;

   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data;
   logic          rd_en;
   logic [IW-1:0] rd_addr;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;

   // register reads
   always_comb begin
      unique case (csr_paddr)
         ADDR_CAPACITY: csr_prdata = cap_ff;
         ADDR_TTL:      csr_prdata = ttl_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // memory port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   logic sweep_end;
   assign sweep_end = (rd_ptr_ff == CW'(ENTRIES));
   assign rd_addr = rd_ptr_ff[IW-1:0];
   assign rd_en = !sweep_end && (state_ff == S_FIND || state_ff == S_LRU ||
                  state_ff == S_BUMP || state_ff == S_DROP || state_ff == S_FREE);

   logic cur_valid;
   assign cur_valid = rd_live_ff && valid_ff[cur_ff];

   // write-back of ranks during shifts, and entry write
   always_comb begin
      wr_en = 1'b0;
      wr_addr = cur_ff;
      wr_data = rd_ff;
      if ((state_ff == S_BUMP || state_ff == S_DROP) && cur_valid) begin
         if (state_ff == S_DROP || mode_ff == SH_DEC) begin
            if (rd_ff.rank > rank_ref_ff) begin
               wr_en = 1'b1;
               wr_data.rank = rd_ff.rank - 1'b1;
            end
         end else if (mode_ff == SH_PROMO) begin
            // promoted entry becomes most recent
            if (cur_ff == slot_ff) begin
               wr_en = 1'b1;
               wr_data.rank = '0;
            end else if (rd_ff.rank < rank_ref_ff) begin
               wr_en = 1'b1;
               wr_data.rank = rd_ff.rank + 1'b1;
            end
         end else begin
            wr_en = 1'b1;
            wr_data.rank = rd_ff.rank + 1'b1;
         end
      end else if (state_ff == S_WRITE) begin
         wr_en = 1'b1;
         wr_addr = slot_ff;
         wr_data.key = key_ff;
         wr_data.pay = pay_ff;
         wr_data.size = size_ff;
         wr_data.expiry = now_ff + TIME_BITS'(ttl_ff);
         wr_data.rank = '0;
      end
   end

   logic [32:0] usage_sub;
   assign usage_sub = usage_ff - 33'(rd_ff.size);

   logic over_budget;
   assign over_budget = usage_ff > {1'b0, cap_ff};

   // first free slot
   logic          free_any;
   logic [IW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         cap_ff <= CAPACITY_RESET;
         ttl_ff <= TTL_RESET;
         usage_ff <= '0;
         now_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == ADDR_CAPACITY) cap_ff <= csr_pwdata;
            if (csr_paddr == ADDR_TTL) ttl_ff <= csr_pwdata;
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         rd_live_ff <= rd_en;
         cur_ff <= rd_addr;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  kind_ff <= req_tuser;
                  key_ff <= KEY_BITS'(req_tdata[31:0]);
                  pay_ff <= req_tdata[63:32];
                  size_ff <= req_tdata[87:64];
                  found_ff <= 1'b0;
                  budget_ff <= 1'b0;
                  evict_ff <= '0;
                  hit_ff <= '0;
                  rd_ptr_ff <= '0;
                  if (req_tuser == REQ_TICK) begin
                     now_ff <= now_ff + 1'b1;
                     status_ff <= ST_TICK;
                     state_ff <= S_OUT;
                  end else if (req_tuser == REQ_PUT && 32'(req_tdata[87:64]) > cap_ff) begin
                     status_ff <= ST_TOO_BIG;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_FIND;
                  end
               end
            end
            S_FIND: begin
               if (cur_valid && rd_ff.key == key_ff && !found_ff) begin
                  found_ff <= 1'b1;
                  slot_ff <= cur_ff;
                  rank_ref_ff <= rd_ff.rank;
               end
               if (rd_en) rd_ptr_ff <= rd_ptr_ff + 1'b1;
               if (sweep_end && !rd_live_ff) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (found_ff) begin
                  // re-read the matched entry for size and expiry
                  rd_ptr_ff <= CW'(slot_ff);
                  mode_ff <= SH_DEC;
                  state_ff <= S_LRU;
               end else begin
                  unique case (kind_ff)
                     REQ_GET:    begin status_ff <= ST_MISS; state_ff <= S_OUT; end
                     REQ_REMOVE: begin status_ff <= ST_ABSENT; state_ff <= S_OUT; end
                     default: begin
                        status_ff <= ST_INSERTED;
                        rd_ptr_ff <= '0;
                        if (free_any) begin
                           slot_ff <= free_idx;
                           mode_ff <= SH_ALL;
                           state_ff <= S_BUMP;
                        end else begin
                           vfound_ff <= 1'b0;
                           state_ff <= S_LRU;
                        end
                     end
                  endcase
               end
            end
            S_LRU: begin
               if (found_ff && !budget_ff) begin
                  // single read of the matched entry
                  if (rd_live_ff) begin
                     if (kind_ff == REQ_GET && now_ff > rd_ff.expiry) begin
                        status_ff <= ST_EXPIRED;
                        usage_ff <= usage_sub;
                        valid_ff[slot_ff] <= 1'b0;
                        state_ff <= S_DROP;
                     end else if (kind_ff == REQ_GET) begin
                        status_ff <= ST_HIT;
                        hit_ff <= rd_ff.pay;
                        mode_ff <= SH_PROMO;
                        state_ff <= S_BUMP;
                     end else if (kind_ff == REQ_REMOVE) begin
                        status_ff <= ST_REMOVED;
                        usage_ff <= usage_sub;
                        valid_ff[slot_ff] <= 1'b0;
                        state_ff <= S_DROP;
                     end else begin
                        status_ff <= ST_UPDATED;
                        usage_ff <= usage_sub;
                        mode_ff <= SH_PROMO;
                        state_ff <= S_BUMP;
                     end
                     rd_ptr_ff <= '0;
                  end else begin
                     // stop after the one read
                     rd_ptr_ff <= CW'(ENTRIES);
                  end
               end else begin
                  // search for the highest rank
                  if (cur_valid && (!vfound_ff || rd_ff.rank > vrank_ff)) begin
                     vfound_ff <= 1'b1;
                     victim_ff <= cur_ff;
                     vrank_ff <= rd_ff.rank;
                  end
                  if (sweep_end && !rd_live_ff) begin
                     rd_ptr_ff <= CW'(victim_ff);
                     state_ff <= S_FREE;
                  end else if (rd_en) begin
                     rd_ptr_ff <= rd_ptr_ff + 1'b1;
                  end
               end
            end
            S_FREE: begin
               // victim entry read back for its size
               if (rd_live_ff) begin
                  if (budget_ff && (!vfound_ff || victim_ff == slot_ff)) begin
                     state_ff <= S_OUT;
                  end else begin
                     usage_ff <= usage_sub;
                     valid_ff[victim_ff] <= 1'b0;
                     rank_ref_ff <= vrank_ff;
                     evict_ff <= evict_ff + 1'b1;
                     rd_ptr_ff <= '0;
                     state_ff <= S_DROP;
                  end
               end else begin
                  rd_ptr_ff <= CW'(ENTRIES);
               end
            end
            S_DROP: begin
               if (sweep_end && !rd_live_ff) begin
                  rd_ptr_ff <= '0;
                  if (budget_ff) begin
                     state_ff <= over_budget ? S_BUDGET : S_OUT;
                  end else if (kind_ff == REQ_PUT) begin
                     slot_ff <= victim_ff;
                     mode_ff <= SH_ALL;
                     state_ff <= S_BUMP;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else if (rd_en) begin
                  rd_ptr_ff <= rd_ptr_ff + 1'b1;
               end
            end
            S_BUMP: begin
               if (sweep_end && !rd_live_ff) begin
                  state_ff <= (kind_ff == REQ_PUT) ? S_WRITE : S_OUT;
               end else if (rd_en) begin
                  rd_ptr_ff <= rd_ptr_ff + 1'b1;
               end
            end
            S_WRITE: begin
               valid_ff[slot_ff] <= 1'b1;
               usage_ff <= usage_ff + 33'(size_ff);
               state_ff <= S_BUDGET;
            end
            S_BUDGET: begin
               if (over_budget) begin
                  budget_ff <= 1'b1;
                  vfound_ff <= 1'b0;
                  rd_ptr_ff <= '0;
                  state_ff <= S_LRU;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff <= {5'd0, CNT_BITS'(evict_ff), usage_ff[31:0], hit_ff, status_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `LTC_ASSERT(a_ready_idle, clock, reset, !req_tready || state_ff == S_IDLE, "ready outside idle")
   `LTC_ASSERT_NEXT(a_out_valid, clock, reset, state_ff == S_OUT && !rsp_valid_ff, rsp_valid_ff, "result lost")
   `LTC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid_ff && !rsp_tready, $stable(rsp_data_ff), "result changed")
endmodule
`default_nettype wire
